[hdl/assert_macros.svh]
// Assertion macros used by the top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The expression must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

[hdl/lfpse_pkg.sv]
package lfpse_pkg;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  localparam int CHANNELS = 3;

  localparam logic [2:0] BYTES_COLOR   = 3'd4;
  localparam logic [2:0] BYTES_TRAILER = 3'd3;

  localparam logic [3:0] NIBBLE_ONE  = 4'h3;
  localparam logic [3:0] NIBBLE_ZERO = 4'h1;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [3:0] tag;
  } issue_t;

  // Each data bit, MSB first, becomes one line nibble.
  function automatic logic [31:0] encode_byte(input logic [7:0] b);
    logic [31:0] word;
    word = '0;
    for (int i = 0; i < 8; i++) begin
      word[4*i +: 4] = b[i] ? NIBBLE_ONE : NIBBLE_ZERO;
    end
    return word;
  endfunction

endpackage

[hdl/led_frame_player_spi_encoder_unit.sv]
// Write item: accepted while the unit is idle, no result.
// Trigger item: 3*LED_COUNT+1 issues through the read and output registers;
// one result per cycle when the output is not stalled (single memory read port).
// On frame counter wrap, the staging store is copied into the active store.
// After reset both stores are zeroed before input is accepted.
`include "assert_macros.svh"

module led_frame_player_spi_encoder_unit import lfpse_pkg::*; #(
  parameter int LED_COUNT   = 16,
  parameter int FRAME_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [3:0]  frame_index_i,
  input  logic [3:0]  led_index_i,
  input  logic [1:0]  color_channel_i,
  input  logic [7:0]  color_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] line_word_o,
  output logic [2:0]  byte_count_o,
  output logic [3:0]  frame_played_o,
  output logic        last_o
);

  localparam int FRAME_BYTES = LED_COUNT * CHANNELS;
  localparam int STORE_BYTES = FRAME_BYTES * FRAME_COUNT;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int IW = $clog2(FRAME_BYTES + 1);
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLAY,
    ST_COPY
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic [IW-1:0] idx_q;
  logic [AW-1:0] base_q;
  logic [FW-1:0] frame_q;
  logic          cp_valid_q;
  logic [AW-1:0] cp_addr_q;

  logic          in_fire;
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic          sweep_last;
  logic          frame_wrap;
  logic [FW+3:0] frame_ext;
  issue_t        issue;
  logic          issue_ready;
  logic          issue_fire;

  logic          stg_we;
  logic [AW-1:0] stg_waddr;
  logic [7:0]    stg_wdata;
  logic          stg_re;
  logic [7:0]    stg_rdata;
  logic          act_we;
  logic [AW-1:0] act_waddr;
  logic [7:0]    act_wdata;
  logic          act_re;
  logic [AW-1:0] act_raddr;
  logic [7:0]    act_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign wr_ok = (opcode_i == OP_WRITE) && (32'(frame_index_i) < FRAME_COUNT) &&
                 (32'(led_index_i) < LED_COUNT) && (32'(color_channel_i) < CHANNELS);
  assign wr_addr = AW'(frame_index_i) * AW'(FRAME_BYTES) +
                   AW'(led_index_i) * AW'(CHANNELS) + AW'(color_channel_i);

  assign sweep_last = (cnt_q == AW'(STORE_BYTES - 1));
  assign frame_wrap = (frame_q == FW'(FRAME_COUNT - 1));
  assign frame_ext  = (FW + 4)'(frame_q);

  assign issue.valid = (state_q == ST_PLAY);
  assign issue.last  = (idx_q == IW'(FRAME_BYTES));
  assign issue.tag   = frame_ext[3:0];
  assign issue_fire  = issue.valid && issue_ready;

  assign stg_we    = (state_q == ST_CLEAR) || (in_fire && wr_ok);
  assign stg_waddr = (state_q == ST_CLEAR) ? cnt_q : wr_addr;
  assign stg_wdata = (state_q == ST_CLEAR) ? 8'h00 : color_value_i;
  assign stg_re    = (state_q == ST_COPY);

  assign act_we    = (state_q == ST_CLEAR) || cp_valid_q;
  assign act_waddr = (state_q == ST_CLEAR) ? cnt_q : cp_addr_q;
  assign act_wdata = (state_q == ST_CLEAR) ? 8'h00 : stg_rdata;
  assign act_re    = issue_fire && !issue.last;
  assign act_raddr = base_q + AW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      idx_q      <= '0;
      base_q     <= '0;
      frame_q    <= '0;
      cp_valid_q <= 1'b0;
      cp_addr_q  <= '0;
    end else begin
      cp_valid_q <= (state_q == ST_COPY);
      cp_addr_q  <= cnt_q;
      case (state_q)
        ST_CLEAR, ST_COPY: begin
          if (sweep_last) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_fire && (opcode_i == OP_TRIGGER)) begin
            state_q <= ST_PLAY;
          end
        end
        ST_PLAY: begin
          if (issue_fire) begin
            if (issue.last) begin
              idx_q <= '0;
              if (frame_wrap) begin
                frame_q <= '0;
                base_q  <= '0;
                state_q <= ST_COPY;
              end else begin
                frame_q <= frame_q + 1'b1;
                base_q  <= base_q + AW'(FRAME_BYTES);
                state_q <= ST_IDLE;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  lfpse_frame_mem #(
    .DEPTH(STORE_BYTES)
  ) u_staging (
    .clk_i  (clk_i),
    .we_i   (stg_we),
    .waddr_i(stg_waddr),
    .wdata_i(stg_wdata),
    .re_i   (stg_re),
    .raddr_i(cnt_q),
    .rdata_o(stg_rdata)
  );

  lfpse_frame_mem #(
    .DEPTH(STORE_BYTES)
  ) u_active (
    .clk_i  (clk_i),
    .we_i   (act_we),
    .waddr_i(act_waddr),
    .wdata_i(act_wdata),
    .re_i   (act_re),
    .raddr_i(act_raddr),
    .rdata_o(act_rdata)
  );

  lfpse_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .rdata_i       (act_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_word_o   (line_word_o),
    .byte_count_o  (byte_count_o),
    .frame_played_o(frame_played_o),
    .last_o        (last_o)
  );

  `ASSERT_NEVER(a_no_act_write_in_play, clk_i, rst_ni, (state_q == ST_PLAY) && act_we)
  `ASSERT_IMPL(a_copy_write_follows_copy, clk_i, rst_ni, cp_valid_q, $past(state_q) == ST_COPY)
  `ASSERT_NEXT(a_trailer_resets_index, clk_i, rst_ni, issue_fire && issue.last, idx_q == '0)
  `ASSERT_NEVER(a_no_read_while_sweep, clk_i, rst_ni,
                act_re && ((state_q == ST_CLEAR) || (state_q == ST_COPY)))

endmodule

[hdl/lfpse_frame_mem.sv]
module lfpse_frame_mem #(
  parameter int DEPTH = 768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lfpse_out_stage.sv]
module lfpse_out_stage import lfpse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  issue_t      issue_i,
  output logic        issue_ready_o,
  input  logic [7:0]  rdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] line_word_o,
  output logic [2:0]  byte_count_o,
  output logic [3:0]  frame_played_o,
  output logic        last_o
);

  logic       b_valid_q;
  logic       b_last_q;
  logic [3:0] b_tag_q;
  logic       c_valid_q;
  logic [31:0] c_word_q;
  logic [2:0]  c_count_q;
  logic [3:0]  c_tag_q;
  logic        c_last_q;
  logic        c_move;
  logic        b_move;

  assign c_move        = !c_valid_q || !out_stall_i;
  assign b_move        = b_valid_q && c_move;
  assign issue_ready_o = !b_valid_q || c_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (issue_ready_o) begin
        b_valid_q <= issue_i.valid;
      end
      if (c_move) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_ready_o && issue_i.valid) begin
      b_last_q <= issue_i.last;
      b_tag_q  <= issue_i.tag;
    end
    if (b_move) begin
      c_word_q  <= b_last_q ? 32'h0 : encode_byte(rdata_i);
      c_count_q <= b_last_q ? BYTES_TRAILER : BYTES_COLOR;
      c_tag_q   <= b_tag_q;
      c_last_q  <= b_last_q;
    end
  end

  assign out_valid_o    = c_valid_q;
  assign line_word_o    = c_word_q;
  assign byte_count_o   = c_count_q;
  assign frame_played_o = c_tag_q;
  assign last_o         = c_last_q;

endmodule

[tb/led_frame_player_spi_encoder_unit_test.sv]
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] word;
  logic [2:0]  nbytes;
  logic [3:0]  frame;
  logic        last;
} line_result_t;

class frame_scoreboard #(int LEDS = 16, int FRAMES = 16);
  localparam int FRAME_BYTES = LEDS * lfpse_pkg::CHANNELS;
  localparam int STORE_BYTES = FRAME_BYTES * FRAMES;

  logic [7:0]   staging[STORE_BYTES];
  logic [7:0]   active[STORE_BYTES];
  int unsigned  play_ptr;
  line_result_t line_q[$];
  int           mismatches;

  function new();
    foreach (staging[i]) begin
      staging[i] = '0;
      active[i]  = '0;
    end
    play_ptr   = 0;
    mismatches = 0;
  endfunction

  // Every data bit, MSB first, becomes one nibble on the line.
  function logic [31:0] spread_bits(logic [7:0] b);
    logic [31:0] word;
    word = '0;
    for (int i = 7; i >= 0; i--) begin
      word = {word[27:0], b[i] ? lfpse_pkg::NIBBLE_ONE : lfpse_pkg::NIBBLE_ZERO};
    end
    return word;
  endfunction

  function void note_item(logic op, logic [3:0] fr, logic [3:0] led, logic [1:0] ch,
                          logic [7:0] val);
    line_result_t r;
    int unsigned  base;
    if (op == lfpse_pkg::OP_WRITE) begin
      if (fr < FRAMES && led < LEDS && ch < lfpse_pkg::CHANNELS) begin
        staging[fr * FRAME_BYTES + led * lfpse_pkg::CHANNELS + ch] = val;
      end
      return;
    end
    base = play_ptr * FRAME_BYTES;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      r.word   = spread_bits(active[base + i]);
      r.nbytes = lfpse_pkg::BYTES_COLOR;
      r.frame  = play_ptr[3:0];
      r.last   = 1'b0;
      line_q.push_back(r);
    end
    r.word   = '0;
    r.nbytes = lfpse_pkg::BYTES_TRAILER;
    r.frame  = play_ptr[3:0];
    r.last   = 1'b1;
    line_q.push_back(r);
    play_ptr++;
    if (play_ptr >= FRAMES) begin
      play_ptr = 0;
      active   = staging;
    end
  endfunction

  function void check_result(logic [31:0] word, logic [2:0] nbytes, logic [3:0] frame,
                             logic last);
    line_result_t r;
    if (line_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result word=%h bytes=%0d frame=%0d last=%b",
                 $realtime, word, nbytes, frame, last);
      end
      return;
    end
    r = line_q.pop_front();
    if (word !== r.word || nbytes !== r.nbytes || frame !== r.frame || last !== r.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: exp %h bytes=%0d frame=%0d last=%b, got %h bytes=%0d frame=%0d last=%b",
                 $realtime, r.word, r.nbytes, r.frame, r.last, word, nbytes, frame, last);
      end
    end
  endfunction

  function int pending();
    return line_q.size();
  endfunction
endclass

module led_frame_player_spi_encoder_unit_test;
  import lfpse_pkg::*;

  localparam int LEDS        = 16;
  localparam int FRAMES      = 16;
  localparam int STORE_BYTES = LEDS * CHANNELS * FRAMES;
  localparam int ITEMS       = 420;
  localparam int MAX_RESULTS = 3 * LEDS + 1;
  localparam int MAX_GAP     = 40;
  localparam int TAIL_CYCLES = STORE_BYTES + 64;
  localparam int CYCLE_LIMIT = 3 * (STORE_BYTES + (ITEMS + 30) *
                               (MAX_RESULTS * (MAX_GAP + 8) + MAX_GAP + STORE_BYTES + 8));

  localparam logic [1:0] CH_RED    = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_BLUE   = 2'd2;
  localparam logic [1:0] CH_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [3:0]  frame_index_i;
  logic [3:0]  led_index_i;
  logic [1:0]  color_channel_i;
  logic [7:0]  color_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] line_word_o;
  logic [2:0]  byte_count_o;
  logic [3:0]  frame_played_o;
  logic        last_o;

  frame_scoreboard #(LEDS, FRAMES) sb;
  bit quiet;
  int cycles = 0;

  led_frame_player_spi_encoder_unit #(
    .LED_COUNT  (LEDS),
    .FRAME_COUNT(FRAMES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .frame_index_i  (frame_index_i),
    .led_index_i    (led_index_i),
    .color_channel_i(color_channel_i),
    .color_value_i  (color_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_word_o    (line_word_o),
    .byte_count_o   (byte_count_o),
    .frame_played_o (frame_played_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic op, logic [3:0] fr, logic [3:0] led, logic [1:0] ch,
                           logic [7:0] val);
    int n;
    @(negedge clk_i);
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    frame_index_i   <= fr;
    led_index_i     <= led;
    color_channel_i <= ch;
    color_value_i   <= val;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, fr, led, ch, val);
  endtask

  task automatic send_trigger();
    send_item(OP_TRIGGER, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(line_word_o, byte_count_o, frame_played_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    quiet = 1'b0;
    forever begin
      repeat ($urandom_range(200, 2000)) @(posedge clk_i);
      quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      n = gap_len();
      @(negedge clk_i);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  initial begin
    int sent;
    int r;
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_WRITE;
    frame_index_i   = '0;
    led_index_i     = '0;
    color_channel_i = CH_RED;
    color_value_i   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extreme indexes and values, the unused channel, then a
    // full round of triggers so the staged data reaches the active store.
    send_item(OP_WRITE, 4'd0, 4'd0, CH_RED, 8'hFF);
    send_item(OP_WRITE, 4'd0, 4'd15, CH_BLUE, 8'h80);
    send_item(OP_WRITE, 4'd15, 4'd15, CH_BLUE, 8'h01);
    send_item(OP_WRITE, 4'd15, 4'd0, CH_GREEN, 8'h55);
    send_item(OP_WRITE, 4'd1, 4'd7, CH_UNUSED, 8'hA5);
    send_item(OP_WRITE, 4'd0, 4'd1, CH_GREEN, 8'hAA);
    send_item(OP_WRITE, 4'd8, 4'd8, CH_RED, 8'h00);
    send_item(OP_WRITE, 4'd1, 4'd0, CH_RED, 8'h7F);
    send_item(OP_TRIGGER, 4'd15, 4'd15, CH_UNUSED, 8'hFF);
    repeat (FRAMES - 1) send_trigger();
    drain();

    sent = 0;
    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (sent == ITEMS / 2) begin
        drain();
      end
      if (r < 18) begin
        send_trigger();
        sent++;
      end else if (r < 23) begin
        send_item(OP_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  CH_UNUSED, pick_value());
      end else begin
        send_item(OP_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 2)), pick_value());
        sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/lfpse_pkg.sv
hdl/lfpse_frame_mem.sv
hdl/lfpse_out_stage.sv
hdl/led_frame_player_spi_encoder_unit.sv
tb/led_frame_player_spi_encoder_unit_test.sv
